// ----- rtl/core/kl_pkg.sv -----
// Package for the keyword lexer: token codes, keyword tables, word state and
// result beat types. No dependencies.
`default_nettype none

package kl_pkg;

   localparam int CHAR_W       = 8;
   localparam int KIND_W       = 4;
   localparam int LEN_W        = 9;
   localparam int MAX_WORD_LEN = 256;
   localparam int NUM_KW       = 5;
   localparam int KW_MAX_LEN   = 5;
   localparam int KW_POS_W     = $clog2(KW_MAX_LEN);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_ADDX     = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_RMX      = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_SHOWX    = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_EXECF    = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_MA       = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_VARIABLE = KIND_W'(5);
   localparam logic [KIND_W-1:0] KIND_NUMBER   = KIND_W'(6);
   localparam logic [KIND_W-1:0] KIND_COLON    = KIND_W'(7);
   localparam logic [KIND_W-1:0] KIND_SQUARE   = KIND_W'(8);
   localparam logic [KIND_W-1:0] KIND_ANGLE    = KIND_W'(9);
   localparam logic [KIND_W-1:0] KIND_ROUND    = KIND_W'(10);
   localparam logic [KIND_W-1:0] KIND_SEMI     = KIND_W'(11);

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3a;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_W-1:0] CH_LSQ    = 8'h5b;
   localparam logic [CHAR_W-1:0] CH_RSQ    = 8'h5d;
   localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3c;
   localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3e;
   localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

   // keyword k, character position p
   localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
      '{8'h61, 8'h64, 8'h64, 8'h78, 8'h00},   // addx
      '{8'h72, 8'h6d, 8'h78, 8'h00, 8'h00},   // rmx
      '{8'h73, 8'h68, 8'h6f, 8'h77, 8'h78},   // showx
      '{8'h65, 8'h78, 8'h65, 8'h63, 8'h66},   // execf
      '{8'h6d, 8'h61, 8'h00, 8'h00, 8'h00}    // ma
   };
   localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
      LEN_W'(4), LEN_W'(3), LEN_W'(5), LEN_W'(5), LEN_W'(2)
   };

   typedef struct packed {
      logic              active;
      logic [LEN_W-1:0]  len;
      logic [NUM_KW-1:0] cand;
      logic              num;
   } word_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              closing;
      logic [LEN_W-1:0]  len;
      logic              last;
   } result_type;

   localparam word_state_type WORD_CLEAR = '{
      active: 1'b0, len: '0, cand: '1, num: 1'b1
   };

endpackage

`default_nettype wire

// ----- rtl/core/kl_scan.sv -----
// Per-byte lexer step: classifies one byte against the running word state and
// gives the next state plus up to two result beats. Depends on kl_pkg.
`default_nettype none

module kl_scan (
   input  wire logic [kl_pkg::CHAR_W-1:0] char_code,
   input  wire logic                      end_of_input,
   input  wire kl_pkg::word_state_type    cur,
   output kl_pkg::word_state_type         nxt,
   output kl_pkg::result_type             res0,
   output kl_pkg::result_type             res1,
   output logic [1:0]                     res_count
);
   import kl_pkg::*;

   logic                 is_ws;
   logic                 is_punct;
   logic [KIND_W-1:0]    punct_kind;
   logic                 punct_close;
   logic                 is_digit;
   word_state_type       base;
   word_state_type       grown;
   logic [KIND_W-1:0]    grown_kind;
   logic [KIND_W-1:0]    cur_kind;
   logic [KW_POS_W-1:0]  pos_lo;

   always_comb begin
      is_ws = char_code inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL};
      is_punct    = 1'b1;
      punct_close = 1'b0;
      punct_kind  = KIND_VARIABLE;
      case (char_code)
         CH_COLON:  punct_kind = KIND_COLON;
         CH_SEMI:   punct_kind = KIND_SEMI;
         CH_LSQ:    punct_kind = KIND_SQUARE;
         CH_RSQ: begin
            punct_kind  = KIND_SQUARE;
            punct_close = 1'b1;
         end
         CH_LANGLE: punct_kind = KIND_ANGLE;
         CH_RANGLE: begin
            punct_kind  = KIND_ANGLE;
            punct_close = 1'b1;
         end
         CH_LPAR:   punct_kind = KIND_ROUND;
         CH_RPAR: begin
            punct_kind  = KIND_ROUND;
            punct_close = 1'b1;
         end
         default:   is_punct = 1'b0;
      endcase
      is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   end

   // absorb the byte into the word
   always_comb begin
      base   = cur.active ? cur : WORD_CLEAR;
      pos_lo = base.len[KW_POS_W-1:0];
      grown  = base;
      grown.active = 1'b1;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!((base.len < KW_LEN[k]) && (KW_TEXT[k][pos_lo] == char_code)))
            grown.cand[k] = 1'b0;
      end
      if (base.len == '0)
         grown.num = is_digit || (char_code == CH_MINUS);
      else if (!is_digit)
         grown.num = 1'b0;
      if (base.len < LEN_W'(MAX_WORD_LEN))
         grown.len = base.len + LEN_W'(1);
   end

   always_comb begin
      grown_kind = grown.num ? KIND_NUMBER : KIND_VARIABLE;
      cur_kind   = cur.num ? KIND_NUMBER : KIND_VARIABLE;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (grown.cand[k] && (grown.len == KW_LEN[k]))
            grown_kind = KIND_W'(k);
         if (cur.cand[k] && (cur.len == KW_LEN[k]))
            cur_kind = KIND_W'(k);
      end
   end

   always_comb begin
      nxt       = cur;
      res0      = '{kind: punct_kind, closing: punct_close, len: LEN_W'(1), last: 1'b1};
      res1      = res0;
      res_count = 2'd0;
      if (!is_ws && !is_punct) begin
         if (end_of_input) begin
            res0      = '{kind: grown_kind, closing: 1'b0, len: grown.len, last: 1'b1};
            res_count = 2'd1;
            nxt       = WORD_CLEAR;
         end else begin
            nxt = grown;
         end
      end else begin
         nxt = WORD_CLEAR;
         if (cur.active) begin
            res0 = '{kind: cur_kind, closing: 1'b0, len: cur.len, last: !is_punct};
            res_count = is_punct ? 2'd2 : 2'd1;
         end else if (is_punct) begin
            res_count = 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/keyword_lexer.sv -----
// Keyword lexer top level: input register, per-byte classifier and a small
// result queue. Depends on kl_pkg and kl_scan.
//
// Takes one source byte per cycle while req_stall is low and reports each
// token's kind and length. A byte is registered on accept and classified
// from that register once the queue has room; its results enter a four-beat
// queue and appear on rsp_ in order from the queue head. A byte yields zero,
// one or two beats, and a new byte can be accepted as the held one advances;
// the input stalls only while three or more beats wait in the queue, which takes
// backpressure on rsp_stall, and stays stalled until the queue is down to two.
`default_nettype none

module keyword_lexer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [kl_pkg::CHAR_W-1:0] req_char_code,
   input  wire logic                      req_end_of_input,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [kl_pkg::KIND_W-1:0]      rsp_token_kind,
   output logic                           rsp_closing,
   output logic [kl_pkg::LEN_W-1:0]       rsp_word_length,
   output logic                           rsp_last_of_run
);
   import kl_pkg::*;

   logic                in_vld_ff, in_vld_in;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                in_eoi_ff;
   word_state_type      word_ff, word_in;
   result_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   word_state_type      scan_nxt;
   result_type          res0, res1;
   logic [1:0]          res_count;
   logic                advance;
   logic                accept;
   logic                pop;
   logic [QCNT_W-1:0]   push_n;
   logic [QPTR_W-1:0]   tail_plus1;

   kl_scan u_scan (
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .cur          (word_ff),
      .nxt          (scan_nxt),
      .res0         (res0),
      .res1         (res1),
      .res_count    (res_count)
   );

   always_comb begin
      advance    = in_vld_ff && (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
      req_stall  = in_vld_ff && !advance;
      accept     = req_valid && !req_stall;
      rsp_valid  = (count_ff != '0);
      pop        = rsp_valid && !rsp_stall;
      push_n     = advance ? QCNT_W'(res_count) : '0;
      tail_plus1 = tail_ff + QPTR_W'(1);

      in_vld_in = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      word_in   = advance ? scan_nxt : word_ff;
      head_in   = pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in   = tail_ff + QPTR_W'(push_n);
      count_in  = count_ff + push_n - QCNT_W'(pop);

      rsp_token_kind  = queue_ff[head_ff].kind;
      rsp_closing     = queue_ff[head_ff].closing;
      rsp_word_length = queue_ff[head_ff].len;
      rsp_last_of_run = queue_ff[head_ff].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         word_ff   <= WORD_CLEAR;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         word_ff   <= word_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
         in_eoi_ff  <= req_end_of_input;
      end
      if (push_n != '0)
         queue_ff[tail_ff] <= res0;
      if (push_n == QCNT_W'(2))
         queue_ff[tail_plus1] <= res1;
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      word_ff.len <= LEN_W'(MAX_WORD_LEN))
      else $error("word length past saturation");

   a_eoi_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eoi_ff) |=> !word_ff.active)
      else $error("word still open after end of input");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("queue pointers disagree with beat count");
`endif

endmodule

`default_nettype wire
